// ===== sv/acsp_pkg.sv =====
// Package for the self-calibrating relay positioner.
// Holds register indexes, mode codes, state encoding and reset values.
// No dependencies.
package acsp_pkg;

   localparam int SENSOR_BITS_DEFAULT     = 16;
   localparam int STEP_COUNT_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SENSOR_FULL      = 3'd0,
      REG_SENSOR_FLOOR     = 3'd1,
      REG_CURRENT_MAX      = 3'd2,
      REG_CURRENT_OFF      = 3'd3,
      REG_TIMEOUT_STEPS    = 3'd4,
      REG_MIN_TRAVEL_STEPS = 3'd5,
      REG_DEADBAND_QUARTER = 3'd6
   } reg_index_type;

   localparam logic [1:0] MODE_UNCAL = 2'd0;
   localparam logic [1:0] MODE_CAL   = 2'd1;
   localparam logic [1:0] MODE_READY = 2'd2;
   localparam logic [1:0] MODE_FAULT = 2'd3;

   typedef enum logic [3:0] {
      ST_UNCAL = 4'b0001,
      ST_CAL   = 4'b0010,
      ST_READY = 4'b0100,
      ST_FAULT = 4'b1000
   } state_type;

   localparam logic [15:0]        SENSOR_FULL_RESET      = 16'hFFFF;
   localparam logic [15:0]        SENSOR_FLOOR_RESET     = 16'h0000;
   localparam logic signed [15:0] CURRENT_MAX_RESET      = 16'sd2000;
   localparam logic signed [15:0] CURRENT_OFF_RESET      = 16'sd50;
   localparam logic [15:0]        TIMEOUT_STEPS_RESET    = 16'd3000;
   localparam logic [15:0]        MIN_TRAVEL_STEPS_RESET = 16'd100;
   localparam logic [15:0]        DEADBAND_QUARTER_RESET = 16'd8;

   function automatic logic [1:0] mode_code(input state_type st);
      logic [1:0] code;
      case (st)
         ST_UNCAL: code = MODE_UNCAL;
         ST_CAL:   code = MODE_CAL;
         ST_READY: code = MODE_READY;
         ST_FAULT: code = MODE_FAULT;
         default:  code = MODE_FAULT;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/actuator_self_calibrating_positioner.sv =====
// Self-calibrating relay positioner: calibration sweeps, then bang-bang regulation.
// Single module with an input register and a result register.
// Depends on acsp_pkg.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid / req_tready | position, motor_current, target
//   rsp     | out       | rsp_tvalid / rsp_tready | relays, mode, learned end points
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// An item passes through the input register and then the result register.
// The state update runs in the cycle the item moves into the result register.
// A new item is taken every cycle unless the result register is full and stalled.
// Reset returns the block to uncalibrated with the default register values.
// The configuration port is always ready.
module actuator_self_calibrating_positioner
   import acsp_pkg::*;
#(
   parameter int SENSOR_BITS     = SENSOR_BITS_DEFAULT,
   parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // position [15:0], motor_current [31:16], target [47:32]
   input  logic [47:0]               req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // drive_forward [0], drive_reverse [1], mode [3:2], low_end [19:4],
   // high_end [35:20], zero [39:36]
   output logic [39:0]               rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [15:0] SENSOR_MASK = (SENSOR_BITS >= 16) ? 16'hFFFF :
                                         16'((1 << SENSOR_BITS) - 1);
   localparam logic [STEP_COUNT_BITS-1:0] STEP_MAX = '1;
   localparam int SW = (STEP_COUNT_BITS > 16) ? STEP_COUNT_BITS : 16;
   localparam int CW = (STEP_COUNT_BITS + 20 > 36) ? STEP_COUNT_BITS + 20 : 36;

   // Configuration registers.
   logic [15:0]        full_ff, floor_ff, timeout_ff, min_travel_ff, deadband_ff;
   logic signed [15:0] cur_max_ff, cur_off_ff;

   // Input register.
   logic               in_valid_ff;
   logic [15:0]        in_pos_ff, in_tgt_ff;
   logic signed [15:0] in_cur_ff;

   // Block state.
   state_type                  state_ff, state_in;
   logic                       fwd_ff, fwd_in, rev_ff, rev_in;
   logic [15:0]                high_ff, high_in, low_ff, low_in;
   logic [STEP_COUNT_BITS-1:0] travel_ff, travel_in, sweep_ff, sweep_in;

   // Result register.
   logic        out_valid_ff;
   logic [39:0] out_data_ff, out_data_in;

   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   // Operands of the step.
   logic [15:0]                pos, tgt, full_m, floor_m, tgt_hi, tgt_c;
   logic                       in_window;
   logic [STEP_COUNT_BITS-1:0] sweep_inc, travel_inc;
   logic [SW-1:0]              sweep_x, sweep_inc_x, timeout_x, min_travel_x;
   logic signed [16:0]         diff, half_full, span, err;
   logic                       bad_high, bad_low;
   logic signed [STEP_COUNT_BITS+17:0] scaled;
   logic signed [33:0]                 band;
   logic signed [CW-1:0]               scaled_x, band_x, span_x, scaled4, scaled2;

   assign pos     = in_pos_ff & SENSOR_MASK;
   assign tgt     = in_tgt_ff & SENSOR_MASK;
   assign full_m  = full_ff & SENSOR_MASK;
   assign floor_m = floor_ff & SENSOR_MASK;

   assign in_window = !(in_cur_ff > cur_max_ff || in_cur_ff < cur_off_ff);

   assign sweep_inc  = (sweep_ff == STEP_MAX) ? sweep_ff : sweep_ff + 1'b1;
   assign travel_inc = (travel_ff == STEP_MAX) ? travel_ff : travel_ff + 1'b1;

   assign sweep_x      = SW'(sweep_ff);
   assign sweep_inc_x  = SW'(sweep_inc);
   assign timeout_x    = SW'(timeout_ff);
   assign min_travel_x = SW'(min_travel_ff);

   assign diff      = $signed({1'b0, high_ff}) - $signed({1'b0, low_ff});
   assign half_full = $signed({2'b00, full_m[15:1]});

   assign bad_high = (high_ff == floor_m) || (high_ff > full_m) ||
                     (high_ff < {2'b00, full_m[15:2]});
   assign bad_low  = (low_ff == full_m) || (low_ff < floor_m) ||
                     (sweep_inc_x < min_travel_x) || (diff < half_full) ||
                     (low_ff > {1'b0, full_m[15:1]});

   assign tgt_hi = (tgt > high_ff) ? high_ff : tgt;
   assign tgt_c  = (tgt_hi < low_ff) ? low_ff : tgt_hi;
   assign span   = (diff <= 17'sd0) ? 17'sd1 : diff;
   assign err    = $signed({1'b0, tgt_c}) - $signed({1'b0, pos});

   assign scaled = (STEP_COUNT_BITS+18)'(err) *
                   (STEP_COUNT_BITS+18)'($signed({1'b0, travel_ff}));
   assign band   = $signed(34'(deadband_ff)) * 34'(span);

   assign scaled_x = CW'(scaled);
   assign band_x   = CW'(band);
   assign span_x   = CW'(span);
   assign scaled4  = scaled_x <<< 2;
   assign scaled2  = scaled_x <<< 1;

   always_comb begin
      state_in  = state_ff;
      fwd_in    = fwd_ff;
      rev_in    = rev_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      travel_in = travel_ff;
      sweep_in  = sweep_ff;
      case (state_ff)
         ST_UNCAL: begin
            state_in = ST_CAL;
            fwd_in   = 1'b1;
            rev_in   = 1'b0;
            high_in  = floor_m;
            low_in   = full_m;
            sweep_in = '0;
         end
         ST_CAL: begin
            if (sweep_x >= timeout_x) begin
               state_in = ST_FAULT;
               fwd_in   = 1'b0;
               rev_in   = 1'b0;
            end else begin
               sweep_in = sweep_inc;
               if (fwd_ff) begin
                  if (in_window && pos > high_ff) begin
                     high_in = pos;
                  end else begin
                     fwd_in = 1'b0;
                     if (bad_high) begin
                        state_in = ST_FAULT;
                        rev_in   = 1'b0;
                     end else begin
                        rev_in    = 1'b1;
                        travel_in = '0;
                        sweep_in  = '0;
                     end
                  end
               end else begin
                  if (in_window && pos < low_ff) begin
                     low_in    = pos;
                     travel_in = travel_inc;
                  end else if (bad_low) begin
                     state_in = ST_FAULT;
                     fwd_in   = 1'b0;
                     rev_in   = 1'b0;
                  end else begin
                     state_in = ST_READY;
                     rev_in   = 1'b0;
                  end
               end
            end
         end
         ST_READY: begin
            if (in_cur_ff > cur_max_ff) begin
               state_in = ST_FAULT;
               fwd_in   = 1'b0;
               rev_in   = 1'b0;
            end else if (scaled4 > band_x) begin
               rev_in = 1'b0;
               fwd_in = 1'b1;
            end else if (scaled4 < -band_x) begin
               fwd_in = 1'b0;
               rev_in = 1'b1;
            end else if (fwd_ff || rev_ff) begin
               if (in_cur_ff < cur_off_ff) begin
                  state_in = ST_FAULT;
                  fwd_in   = 1'b0;
                  rev_in   = 1'b0;
               end else if (fwd_ff) begin
                  if (scaled2 < span_x) begin
                     fwd_in = 1'b0;
                  end
               end else begin
                  if (scaled2 > -span_x) begin
                     rev_in = 1'b0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_data_in = {4'b0000, high_in, low_in, mode_code(state_in), rev_in, fwd_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= SENSOR_FULL_RESET;
         floor_ff      <= SENSOR_FLOOR_RESET;
         cur_max_ff    <= CURRENT_MAX_RESET;
         cur_off_ff    <= CURRENT_OFF_RESET;
         timeout_ff    <= TIMEOUT_STEPS_RESET;
         min_travel_ff <= MIN_TRAVEL_STEPS_RESET;
         deadband_ff   <= DEADBAND_QUARTER_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SENSOR_FULL:      full_ff       <= csr_data;
            REG_SENSOR_FLOOR:     floor_ff      <= csr_data;
            REG_CURRENT_MAX:      cur_max_ff    <= $signed(csr_data);
            REG_CURRENT_OFF:      cur_off_ff    <= $signed(csr_data);
            REG_TIMEOUT_STEPS:    timeout_ff    <= csr_data;
            REG_MIN_TRAVEL_STEPS: min_travel_ff <= csr_data;
            REG_DEADBAND_QUARTER: deadband_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_UNCAL;
         fwd_ff       <= 1'b0;
         rev_ff       <= 1'b0;
         high_ff      <= SENSOR_FLOOR_RESET & SENSOR_MASK;
         low_ff       <= SENSOR_FULL_RESET & SENSOR_MASK;
         travel_ff    <= '0;
         sweep_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
            fwd_ff       <= fwd_in;
            rev_ff       <= rev_in;
            high_ff      <= high_in;
            low_ff       <= low_in;
            travel_ff    <= travel_in;
            sweep_ff     <= sweep_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pos_ff <= req_tdata[15:0];
         in_cur_ff <= $signed(req_tdata[31:16]);
         in_tgt_ff <= req_tdata[47:32];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
